// ===== rtl/f2d_pkg.sv =====
// ----------------------------------------------------------------------------
// f2d_pkg
// Shared constants and helpers for the float32 to 96-bit decimal converter.
// ----------------------------------------------------------------------------
package f2d_pkg;

    // decimal format limits
    localparam int MAX_DEC_SCALE = 28;
    localparam int SIG_DIGITS    = 7;
    localparam int COEFF_W       = 96;
    localparam int SCALE_W       = 5;

    // elaboration-time power of ten
    function automatic longint unsigned pow10_c(input int n);
        longint unsigned v;
        v = 1;
        for (int i = 0; i < n; i++) begin
            v = v * 10;
        end
        return v;
    endfunction

    // one past the largest rounded coefficient
    localparam longint unsigned LIM = pow10_c(SIG_DIGITS);
    localparam int Q_W = $clog2(LIM + 1);

    // datapath widths: working value, shifted divisor, signed scale
    localparam int A_W = 124;
    localparam int D_W = A_W + Q_W;
    localparam int K_W = 7;

    // single-precision exponent codes
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] EXP_TOO_BIG  = 8'(127 + COEFF_W);
    localparam logic [7:0] EXP_INT      = 8'd150;
    localparam logic [7:0] SUBN_SHIFT   = 8'd149;

    // times ten through two shifts and one add
    function automatic logic [D_W-1:0] mul10(input logic [D_W-1:0] x);
        return (x << 3) + (x << 1);
    endfunction

endpackage

// ===== rtl/f2d_div10.sv =====
// ----------------------------------------------------------------------------
// f2d_div10
// Divide a rounded coefficient by ten through a reciprocal multiply and flag
// a zero remainder, for trailing zero stripping.
// ----------------------------------------------------------------------------
module f2d_div10 (
    input  logic [f2d_pkg::Q_W-1:0] i_val,
    output logic [f2d_pkg::Q_W-1:0] o_quot,
    output logic                    o_rem_zero
);

    logic [63:0] w_prod;
    logic [31:0] w_quot;
    logic [31:0] w_back;

    // floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for any 32-bit x
    assign w_prod = {32'd0, 32'(i_val)} * 64'h0000_0000_CCCC_CCCD;
    assign w_quot = w_prod[63:32] >> 3;

    // quotient times ten matches only when the remainder is zero
    assign w_back     = (w_quot << 3) + (w_quot << 1);
    assign o_rem_zero = (w_back == 32'(i_val));
    assign o_quot     = f2d_pkg::Q_W'(w_quot);

endmodule

// ===== rtl/float_to_decimal128_convert_unit.sv =====
// ----------------------------------------------------------------------------
// float_to_decimal128_convert_unit
// Converts an IEEE single-precision word to a 96-bit decimal coefficient with
// sign, scale and status, rounded half to even to a fixed digit count.
// Sequence per request: decode, digit scan steps, restoring divide steps,
// rounding, trailing zero strip and scale steps, then hand off; special
// values go from decode straight to hand off.
// Throughput: one request at a time; a shared compare/subtract unit and a
// times-ten adder are stepped by the sequencer. A finished result sits in an
// output register so the next request may start before it is taken.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module float_to_decimal128_convert_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_coeff_low,
    output logic [31:0] o_coeff_high,
    output logic [4:0]  o_dec_scale,
    output logic        o_negative,
    output logic        o_status
);

    localparam int A_W   = f2d_pkg::A_W;
    localparam int D_W   = f2d_pkg::D_W;
    localparam int Q_W   = f2d_pkg::Q_W;
    localparam int K_W   = f2d_pkg::K_W;
    localparam int CNT_W = $clog2(Q_W);

    localparam logic signed [K_W-1:0] K_ONE = K_W'(1);
    localparam logic signed [K_W-1:0] K_ZERO = K_W'(0);
    localparam logic signed [K_W-1:0] K_MAX = K_W'(f2d_pkg::MAX_DEC_SCALE);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCANH = 3'd1;
    localparam logic [2:0] S_SCANL = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_STRIP = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]               r_state, n_state;
    logic [A_W-1:0]           r_a, n_a;
    logic [D_W-1:0]           r_t, n_t;
    logic [D_W-1:0]           r_d, n_d;
    logic [Q_W-1:0]           r_q, n_q;
    logic signed [K_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_low, n_low;
    logic                     r_sign, n_sign;
    logic                     r_err, n_err;
    logic                     r_zero, n_zero;

    logic                     r_ovalid, n_ovalid;
    logic [f2d_pkg::COEFF_W-1:0] r_ocoeff, n_ocoeff;
    logic [f2d_pkg::SCALE_W-1:0] r_oscale, n_oscale;
    logic                     r_oneg, n_oneg;
    logic                     r_ostat, n_ostat;

    logic [7:0]               w_ef;
    logic [22:0]              w_fr;
    logic [23:0]              w_mant;
    logic [7:0]               w_shl;
    logic [7:0]               w_s;
    logic [8:0]               w_dsh;
    logic [D_W-1:0]           w_a10;
    logic [D_W-1:0]           w_cmp_a, w_cmp_b;
    logic [D_W:0]             w_diff;
    logic                     w_ge, w_eq, w_up;
    logic [Q_W-1:0]           w_qr;
    logic [Q_W-1:0]           w_q10;
    logic                     w_rz;
    logic                     w_done;

    // field decode of the incoming word
    assign w_ef   = i_float_bits[30:23];
    assign w_fr   = i_float_bits[22:0];
    assign w_mant = {(w_ef != 8'd0), w_fr};
    assign w_shl  = w_ef - f2d_pkg::EXP_INT;
    assign w_s    = (w_ef == 8'd0) ? f2d_pkg::SUBN_SHIFT : (f2d_pkg::EXP_INT - w_ef);
    assign w_dsh  = 9'(w_s) + 9'(Q_W - 1);

    // times-ten adder on the working value
    assign w_a10 = f2d_pkg::mul10(D_W'(r_a));

    // shared compare/subtract unit
    always_comb begin
        case (r_state)
            S_SCANH: begin
                w_cmp_a = D_W'(r_a);
                w_cmp_b = r_t;
            end
            S_SCANL: begin
                w_cmp_a = w_a10;
                w_cmp_b = r_t;
            end
            S_ROUND: begin
                w_cmp_a = D_W'({r_a, 1'b0});
                w_cmp_b = r_d;
            end
            default: begin
                w_cmp_a = D_W'(r_a);
                w_cmp_b = r_d;
            end
        endcase
    end

    assign w_diff = {1'b0, w_cmp_a} - {1'b0, w_cmp_b};
    assign w_ge   = ~w_diff[D_W];
    assign w_eq   = (w_diff == '0);

    // half to even: above half, or exactly half with an odd quotient
    assign w_up = (w_ge & ~w_eq) | (w_eq & r_q[0]);
    assign w_qr = r_q + Q_W'(w_up);

    // divide by ten for zero stripping
    f2d_div10 u_div10 (
        .i_val      (r_q),
        .o_quot     (w_q10),
        .o_rem_zero (w_rz)
    );

    assign w_done = ~r_ovalid | i_ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_t     = r_t;
        n_d     = r_d;
        n_q     = r_q;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_low   = r_low;
        n_sign  = r_sign;
        n_err   = r_err;
        n_zero  = r_zero;
        n_ovalid = r_ovalid;
        n_ocoeff = r_ocoeff;
        n_oscale = r_oscale;
        n_oneg   = r_oneg;
        n_ostat  = r_ostat;

        // output register drains independently
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sign = i_float_bits[31];
                    n_err  = 1'b0;
                    n_zero = 1'b0;
                    n_k    = K_ZERO;
                    if (w_ef == f2d_pkg::EXP_ALL_ONES || w_ef >= f2d_pkg::EXP_TOO_BIG) begin
                        n_err   = 1'b1;
                        n_state = S_FIN;
                    end else if (w_ef == 8'd0 && w_fr == 23'd0) begin
                        n_zero  = 1'b1;
                        n_state = S_FIN;
                    end else if (w_ef >= f2d_pkg::EXP_INT) begin
                        // integer value: scan digits against 10^(digits + j)
                        n_low   = 1'b0;
                        n_a     = A_W'(w_mant) << w_shl;
                        n_t     = D_W'(f2d_pkg::LIM);
                        n_d     = D_W'(1) << (Q_W - 1);
                        n_state = S_SCANH;
                    end else if (w_s >= 8'(A_W)) begin
                        // far below the smallest decimal step
                        n_err   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        // fraction: scale up by ten while it stays in range
                        n_low   = 1'b1;
                        n_a     = A_W'(w_mant);
                        n_t     = D_W'(f2d_pkg::LIM) << w_s;
                        n_d     = D_W'(1) << w_dsh;
                        n_state = S_SCANL;
                    end
                end
            end
            S_SCANH: begin
                if (w_ge) begin
                    n_t = f2d_pkg::mul10(r_t);
                    n_d = f2d_pkg::mul10(r_d);
                    n_k = r_k - K_ONE;
                end else begin
                    n_cnt   = CNT_W'(Q_W - 1);
                    n_state = S_DIV;
                end
            end
            S_SCANL: begin
                if (r_k < K_MAX && !w_ge) begin
                    n_a = A_W'(w_a10);
                    n_k = r_k + K_ONE;
                end else begin
                    n_cnt   = CNT_W'(Q_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per step
                if (w_ge) begin
                    n_a = A_W'(w_diff);
                end
                n_q = {r_q[Q_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = S_ROUND;
                end else begin
                    n_d   = r_d >> 1;
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_ROUND: begin
                if (r_low && r_q == '0) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else if (w_qr == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_FIN;
                end else if (w_qr == Q_W'(f2d_pkg::LIM)) begin
                    // carried into an extra digit
                    n_q     = Q_W'(f2d_pkg::LIM / 10);
                    n_k     = r_k - K_ONE;
                    n_state = S_STRIP;
                end else begin
                    n_q     = w_qr;
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (r_k > K_ZERO && w_rz) begin
                    n_q = w_q10;
                    n_k = r_k - K_ONE;
                end else begin
                    n_a     = A_W'(r_q);
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (r_k < K_ZERO) begin
                    n_a = A_W'(w_a10);
                    n_k = r_k + K_ONE;
                end else begin
                    if (r_a[A_W-1:f2d_pkg::COEFF_W] != '0) begin
                        n_err = 1'b1;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_done) begin
                    n_ovalid = 1'b1;
                    if (r_err || r_zero) begin
                        n_ocoeff = '0;
                        n_oscale = '0;
                        n_oneg   = 1'b0;
                    end else begin
                        n_ocoeff = r_a[f2d_pkg::COEFF_W-1:0];
                        n_oscale = r_k[f2d_pkg::SCALE_W-1:0];
                        n_oneg   = r_sign;
                    end
                    n_ostat = r_err;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_t      <= n_t;
        r_d      <= n_d;
        r_q      <= n_q;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_low    <= n_low;
        r_sign   <= n_sign;
        r_err    <= n_err;
        r_zero   <= n_zero;
        r_ocoeff <= n_ocoeff;
        r_oscale <= n_oscale;
        r_oneg   <= n_oneg;
        r_ostat  <= n_ostat;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_coeff_low  = r_ocoeff[63:0];
    assign o_coeff_high = r_ocoeff[95:64];
    assign o_dec_scale  = r_oscale;
    assign o_negative   = r_oneg;
    assign o_status     = r_ostat;

`ifndef SYNTHESIS
    // an accepted request keeps the sequencer busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer ready right after accepting a request");

    // error results carry an all-zero payload
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
        (o_coeff_low == 64'd0 && o_coeff_high == 32'd0 && o_dec_scale == 5'd0 && !o_negative))
        else $error("error result with nonzero payload");

    // scale never exceeds the decimal limit
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dec_scale <= 5'(f2d_pkg::MAX_DEC_SCALE)))
        else $error("decimal scale out of range");

    // a pending result is not overwritten before it is taken
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_coeff_low) && $stable(o_status)))
        else $error("pending result changed while stalled");
`endif

endmodule
